// ===== hw/rtl/opp_pkg.sv =====
package opp_pkg;

   // Parser phase
   typedef enum logic [3:0] {
      PH_ROOT = 4'd0,
      PH_SEP  = 4'd1,
      PH_PFX  = 4'd2,
      PH_DIG1 = 4'd3,
      PH_DIGN = 4'd4
   } phase_type;

   // Sticky error codes as reported on the result
   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_EMPTY     = 3'd1,
      ERR_BAD_ROOT  = 3'd2,
      ERR_NO_DOT    = 3'd3,
      ERR_NO_PREFIX = 3'd4,
      ERR_NO_DIGIT  = 3'd5,
      ERR_NO_CLOSE  = 3'd6,
      ERR_TOO_LARGE = 3'd7
   } err_type;

   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned STEP_W  = 14;
   localparam int unsigned ERR_W   = 3;
   localparam int unsigned REQ_W   = 8;   // character
   localparam int unsigned RSP_W   = 24;  // step_value, error_code, path_ok, padding
   localparam int unsigned ADDR_W  = 3;

   localparam logic [STEP_W-1:0] LIMIT_RESET = 14'd1000;
   localparam logic [ADDR_W-1:0] ADDR_INDEX_LIMIT = 3'd0;

   localparam logic [CHAR_W-1:0] CH_L     = 8'h6c;  // 'l'
   localparam logic [CHAR_W-1:0] CH_R     = 8'h72;  // 'r'
   localparam logic [CHAR_W-1:0] CH_H     = 8'h68;  // 'h'
   localparam logic [CHAR_W-1:0] CH_S     = 8'h73;  // 's'
   localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2e;  // '.'
   localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h5d;  // ']'
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;  // '0'
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;  // '9'

   // Characters of "operand[" by position
   function automatic logic [CHAR_W-1:0] prefix_char(input logic [2:0] pos);
      logic [CHAR_W-1:0] c;
      case (pos)
         3'd0:    c = 8'h6f;  // 'o'
         3'd1:    c = 8'h70;  // 'p'
         3'd2:    c = 8'h65;  // 'e'
         3'd3:    c = 8'h72;  // 'r'
         3'd4:    c = 8'h61;  // 'a'
         3'd5:    c = 8'h6e;  // 'n'
         3'd6:    c = 8'h64;  // 'd'
         default: c = 8'h5b;  // '['
      endcase
      return c;
   endfunction

endpackage

// ===== hw/rtl/operand_path_parser_top.sv =====
// Operand path parser.
// Takes a path string one byte per request on the req_ stream and checks it
// against the grammar  ("lhs" | "rhs") { ".operand[" digits "]" }.
// req_tdata carries the byte, req_tuser is 1 when the byte is valid (0 for an
// end-only marker) and req_tlast ends the string.
// One response leaves on the rsp_ stream for every request. rsp_tuser flags a
// completed step (root: 0 lhs, 1 rhs; segment: the decimal index). The first
// error sticks until the string ends; the response to the last request has
// rsp_tlast set and carries the final error code and the path_ok flag.
// csr_ holds one register, index_limit (byte address 0, reset 1000): the
// largest index accepted before "index too large" is reported at its ']'.
// A request accepted on req_ is held in the request register and its response
// in the response register. Throughput: one request per cycle while rsp_tready
// is high, as the parser state update (including the multiply-by-ten index
// accumulate) is combinational between the two registers.
// Stalls: while rsp_tready is low the response holds and one further request
// is still taken into the request register; after that req_tready drops.
// Reset (synchronous, active high) empties both registers, returns the parser
// to the start of a root and restores index_limit to 1000.
module operand_path_parser_top (
   input  logic                          clock,
   input  logic                          reset,
   // request stream
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [opp_pkg::REQ_W-1:0]     req_tdata,   // [7:0] character
   input  logic                          req_tuser,   // [0] has_char
   input  logic                          req_tlast,   // last
   // response stream
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [opp_pkg::RSP_W-1:0]     rsp_tdata,   // [13:0] step_value,
                                                      // [16:14] error_code,
                                                      // [17] path_ok, [23:18] zero
   output logic                          rsp_tuser,   // [0] step_valid
   output logic                          rsp_tlast,   // done_res
   // configuration
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [opp_pkg::ADDR_W-1:0]    csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   import opp_pkg::*;

   // request register
   logic              in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0] in_char_ff;
   logic              in_has_ff;
   logic              in_last_ff;

   // response register
   logic              out_valid_ff, out_valid_in;
   logic [STEP_W-1:0] out_step_ff, out_step_in;
   logic              out_sv_ff, out_sv_in;
   err_type           out_err_ff, out_err_in;
   logic              out_done_ff;
   logic              out_ok_ff, out_ok_in;

   // parser state
   phase_type         phase_ff, phase_in;
   logic [2:0]        pos_ff, pos_in;
   logic              rhs_ff, rhs_in;
   logic [STEP_W-1:0] acc_ff, acc_in;
   logic              ovf_ff, ovf_in;
   err_type           err_ff, err_in;
   logic              seen_ff, seen_in;

   logic [STEP_W-1:0] limit_ff;

   logic              accept;
   logic              advance;
   logic              is_digit;
   logic [17:0]       acc_next;
   err_type           fin_err;

   // Move the held request into the response register when that is free
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   assign is_digit = in_char_ff inside {[CH_ZERO:CH_NINE]};
   assign acc_next = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                   + {14'd0, in_char_ff[3:0]};

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   // Parser next state and response fields
   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      rhs_in    = rhs_ff;
      acc_in    = acc_ff;
      ovf_in    = ovf_ff;
      err_in    = err_ff;
      seen_in   = seen_ff;
      out_sv_in = 1'b0;
      out_step_in = '0;
      fin_err   = err_ff;
      if (advance && in_has_ff) begin
         seen_in = 1'b1;
         // once an error is held, drop every further character
         if (err_ff == ERR_NONE) begin
            case (phase_ff)
               PH_ROOT: begin
                  if (pos_ff == 3'd0) begin
                     if (in_char_ff == CH_L) begin
                        rhs_in = 1'b0;
                        pos_in = 3'd1;
                     end else if (in_char_ff == CH_R) begin
                        rhs_in = 1'b1;
                        pos_in = 3'd1;
                     end else begin
                        err_in = ERR_BAD_ROOT;
                     end
                  end else if (pos_ff == 3'd1) begin
                     if (in_char_ff == CH_H) begin
                        pos_in = 3'd2;
                     end else begin
                        err_in = ERR_BAD_ROOT;
                     end
                  end else if (in_char_ff == CH_S) begin
                     phase_in    = PH_SEP;
                     pos_in      = 3'd0;
                     out_sv_in   = 1'b1;
                     out_step_in = {{(STEP_W-1){1'b0}}, rhs_ff};
                  end else begin
                     err_in = ERR_BAD_ROOT;
                  end
               end
               PH_SEP: begin
                  if (in_char_ff == CH_DOT) begin
                     phase_in = PH_PFX;
                     pos_in   = 3'd0;
                  end else begin
                     err_in = ERR_NO_DOT;
                  end
               end
               PH_PFX: begin
                  if (in_char_ff == prefix_char(pos_ff)) begin
                     if (pos_ff == 3'd7) begin
                        phase_in = PH_DIG1;
                        pos_in   = 3'd0;
                        acc_in   = '0;
                        ovf_in   = 1'b0;
                     end else begin
                        pos_in = pos_ff + 3'd1;
                     end
                  end else begin
                     err_in = ERR_NO_PREFIX;
                  end
               end
               PH_DIG1, PH_DIGN: begin
                  if (is_digit) begin
                     phase_in = PH_DIGN;
                     // freeze the index once it has passed the limit
                     if (!ovf_ff) begin
                        if (acc_next > {4'd0, limit_ff}) begin
                           ovf_in = 1'b1;
                        end else begin
                           acc_in = acc_next[STEP_W-1:0];
                        end
                     end
                  end else if (phase_ff == PH_DIG1) begin
                     err_in = ERR_NO_DIGIT;
                  end else if (in_char_ff == CH_CLOSE) begin
                     if (ovf_ff) begin
                        err_in = ERR_TOO_LARGE;
                     end else begin
                        phase_in    = PH_SEP;
                        out_sv_in   = 1'b1;
                        out_step_in = acc_ff;
                     end
                  end else begin
                     err_in = ERR_NO_CLOSE;
                  end
               end
               default: begin
                  err_in = err_ff;
               end
            endcase
         end
      end
      fin_err = err_in;
      if (advance && in_last_ff) begin
         // completion check on the end of the string
         if (err_in == ERR_NONE) begin
            if (!seen_in) begin
               fin_err = ERR_EMPTY;
            end else begin
               case (phase_in)
                  PH_SEP:  fin_err = ERR_NONE;
                  PH_ROOT: fin_err = ERR_BAD_ROOT;
                  PH_PFX:  fin_err = ERR_NO_PREFIX;
                  PH_DIG1: fin_err = ERR_NO_DIGIT;
                  default: fin_err = ERR_NO_CLOSE;
               endcase
            end
         end
         // return to the start for the next string
         phase_in = PH_ROOT;
         pos_in   = 3'd0;
         rhs_in   = 1'b0;
         acc_in   = '0;
         ovf_in   = 1'b0;
         err_in   = ERR_NONE;
         seen_in  = 1'b0;
      end
      out_err_in = fin_err;
      out_ok_in  = in_last_ff && (fin_err == ERR_NONE);
   end

   // Control and parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_ROOT;
         pos_ff       <= 3'd0;
         rhs_ff       <= 1'b0;
         acc_ff       <= '0;
         ovf_ff       <= 1'b0;
         err_ff       <= ERR_NONE;
         seen_ff      <= 1'b0;
         limit_ff     <= LIMIT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         rhs_ff       <= rhs_in;
         acc_ff       <= acc_in;
         ovf_ff       <= ovf_in;
         err_ff       <= err_in;
         seen_ff      <= seen_in;
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
               && (csr_paddr == ADDR_INDEX_LIMIT)) begin
            limit_ff <= csr_pwdata[STEP_W-1:0];
         end
      end
   end

   // Payload: hold the request and response data while stalled
   always_ff @(posedge clock) begin
      if (accept) begin
         in_char_ff <= req_tdata[CHAR_W-1:0];
         in_has_ff  <= req_tuser;
         in_last_ff <= req_tlast;
      end
      if (advance) begin
         out_step_ff <= out_step_in;
         out_sv_ff   <= out_sv_in;
         out_err_ff  <= out_err_in;
         out_done_ff <= in_last_ff;
         out_ok_ff   <= out_ok_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_ok_ff, out_err_ff, out_step_ff};
   assign rsp_tuser  = out_sv_ff;
   assign rsp_tlast  = out_done_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == ADDR_INDEX_LIMIT) ? {18'd0, limit_ff} : 32'd0;

endmodule

// ===== hw/rtl/opp_checker.sv =====
module opp_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [opp_pkg::RSP_W-1:0]     rsp_tdata,
   input logic                          rsp_tuser,
   input logic                          rsp_tlast
);
   import opp_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   // path_ok only on the end of a string with no error
   a_ok_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[17] |-> rsp_tlast && (rsp_tdata[16:14] == ERR_NONE))
      else $error("path_ok without a clean end of string");

   // a clean end of string must report path_ok
   a_done_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast && (rsp_tdata[16:14] == ERR_NONE) |-> rsp_tdata[17])
      else $error("clean end of string without path_ok");

   // no step value without a step
   a_step_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> (rsp_tdata[13:0] == '0))
      else $error("step value without step_valid");

   // reset empties the response register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind operand_path_parser_top opp_checker u_opp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
